// ----- rtl/lrukh_pkg.sv -----
// Shared types and constants of the LRU-K access history table.
// Used by every module of the block; depends on nothing.
package lrukh_pkg;

  localparam int unsigned NUM_OBJECTS_DEF = 256;
  localparam int unsigned MAX_K_DEF       = 8;
  localparam int unsigned STAMP_WIDTH_DEF = 48;

  localparam int unsigned OBJ_W   = 8;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TMS_W   = 48;
  localparam int unsigned EVICT_W = 48;
  localparam int unsigned KDEP_W  = 4;

  localparam int unsigned S_TDATA_W = 88;
  localparam int unsigned M_TDATA_W = 48;

  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_K_DEPTH    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_STAMP_MODE = 1'b1;

  localparam logic [KDEP_W-1:0] K_DEPTH_RST    = 4'd2;
  localparam logic              STAMP_MODE_RST = 1'b0;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_READ
  } state_e;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/lrukh_ctrl.sv -----
// Sequencer of the LRU-K history table: capture, lookup, read-out.
// Depends on lrukh_pkg; drives the datapath through cmd_t and reads sts_t.
module lrukh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lrukh_pkg::sts_t   sts_i,
  output lrukh_pkg::cmd_t   cmd_o
);

  lrukh_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrukh_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lrukh_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lrukh_pkg::ST_LOOKUP;
      end
      lrukh_pkg::ST_LOOKUP: begin
        state_d = sts_i.is_query ? lrukh_pkg::ST_READ : lrukh_pkg::ST_IDLE;
      end
      lrukh_pkg::ST_READ: begin
        if (sts_i.out_free) state_d = lrukh_pkg::ST_IDLE;
      end
      default: state_d = lrukh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    case (state_q)
      lrukh_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      lrukh_pkg::ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
      end
      lrukh_pkg::ST_READ: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/lrukh_dp.sv -----
// Datapath of the LRU-K history table: registers, ring metadata, stamp memory,
// result register. Depends on lrukh_pkg; steered by lrukh_ctrl.
module lrukh_dp #(
  parameter int unsigned NUM_OBJECTS = lrukh_pkg::NUM_OBJECTS_DEF,
  parameter int unsigned MAX_K       = lrukh_pkg::MAX_K_DEF,
  parameter int unsigned STAMP_WIDTH = lrukh_pkg::STAMP_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lrukh_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [lrukh_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              op_i,
  input  logic [lrukh_pkg::OBJ_W-1:0]       object_index_i,
  input  logic [lrukh_pkg::CNT_W-1:0]       access_count_i,
  input  logic [lrukh_pkg::TMS_W-1:0]       access_time_ms_i,
  input  lrukh_pkg::cmd_t                   cmd_i,
  output lrukh_pkg::sts_t                   sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lrukh_pkg::EVICT_W-1:0]     evict_value_o,
  output logic                              has_history_o
);

  localparam int unsigned NOBJ   = (NUM_OBJECTS < (2 ** lrukh_pkg::OBJ_W)) ?
                                   NUM_OBJECTS : (2 ** lrukh_pkg::OBJ_W);
  localparam int unsigned OW     = $clog2(NOBJ);
  localparam int unsigned KW     = $clog2(MAX_K + 1);
  localparam int unsigned HW     = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned DEPTH  = NOBJ * MAX_K;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned MW     = KW + HW;

  logic [lrukh_pkg::KDEP_W-1:0] k_depth_q;
  logic                         stamp_mode_q;

  logic                         op_q;
  logic [lrukh_pkg::OBJ_W-1:0]  obj_q;
  logic [lrukh_pkg::CNT_W-1:0]  cnt_q;
  logic [lrukh_pkg::TMS_W-1:0]  tms_q;

  logic [MW-1:0]                meta_mem [NOBJ];
  logic [MW-1:0]                meta_rd_q;
  logic [NOBJ-1:0]              vld_q;
  logic                         vld_rd_q;

  logic [STAMP_WIDTH-1:0]       stamp_mem [DEPTH];
  logic [STAMP_WIDTH-1:0]       stamp_rd_q;
  logic                         hit_q;

  logic                         out_valid_q;
  logic [lrukh_pkg::EVICT_W-1:0] evict_q;
  logic                         has_q;

  logic [KW-1:0]                k_eff;
  logic [OW-1:0]                cap_idx;
  logic [OW-1:0]                obj_idx;
  logic                         in_range;
  logic [KW-1:0]                fill;
  logic [HW-1:0]                head;
  logic [KW-1:0]                head_inc;
  logic [HW-1:0]                head_nxt;
  logic [KW-1:0]                fill_nxt;
  logic [KW:0]                  slot_sum;
  logic [KW:0]                  slot_wrap;
  logic [HW-1:0]                slot;
  logic [AW-1:0]                base_addr;
  logic [AW-1:0]                wr_addr;
  logic [AW-1:0]                rd_addr;
  logic [STAMP_WIDTH-1:0]       stamp;
  logic                         do_write;

  always_comb begin
    if (k_depth_q == '0) begin
      k_eff = KW'(1);
    end else if (32'(k_depth_q) > MAX_K) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = KW'(k_depth_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_depth_q    <= lrukh_pkg::K_DEPTH_RST;
      stamp_mode_q <= lrukh_pkg::STAMP_MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lrukh_pkg::REG_K_DEPTH:    k_depth_q    <= cfg_data_i;
        lrukh_pkg::REG_STAMP_MODE: stamp_mode_q <= cfg_data_i[0];
        default:                   stamp_mode_q <= stamp_mode_q;
      endcase
    end
  end

  assign cap_idx = object_index_i[OW-1:0];
  assign obj_idx = obj_q[OW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= op_i;
      obj_q    <= object_index_i;
      cnt_q    <= access_count_i;
      tms_q    <= access_time_ms_i;
      vld_rd_q <= vld_q[cap_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      meta_rd_q <= meta_mem[cap_idx];
    end
  end

  assign in_range = 32'(obj_q) < NUM_OBJECTS;
  assign fill     = vld_rd_q ? meta_rd_q[MW-1:HW] : '0;
  assign head     = vld_rd_q ? meta_rd_q[HW-1:0] : '0;
  assign head_inc = KW'(head) + KW'(1);
  assign head_nxt = (head_inc == k_eff) ? '0 : HW'(head_inc);
  assign fill_nxt = (fill < k_eff) ? fill + KW'(1) : fill;

  assign slot_sum  = (KW + 1)'(head) + (KW + 1)'(k_eff) - (KW + 1)'(fill);
  assign slot_wrap = (slot_sum >= (KW + 1)'(k_eff)) ? slot_sum - (KW + 1)'(k_eff) : slot_sum;
  assign slot      = HW'(slot_wrap);

  assign base_addr = AW'(obj_idx) * AW'(MAX_K);
  assign wr_addr   = base_addr + AW'(head);
  assign rd_addr   = base_addr + AW'(slot);

  assign stamp    = stamp_mode_q ? STAMP_WIDTH'(cnt_q) : STAMP_WIDTH'(tms_q);
  assign do_write = cmd_i.lookup && (op_q == lrukh_pkg::OP_ACCESS) && in_range;

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      meta_mem[obj_idx] <= {fill_nxt, head_nxt};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cfg_we_i && (cfg_addr_i == lrukh_pkg::REG_K_DEPTH)) begin
      vld_q <= '0;
    end else if (do_write) begin
      vld_q[obj_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      stamp_mem[wr_addr] <= stamp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup && (op_q == lrukh_pkg::OP_QUERY)) begin
      stamp_rd_q <= stamp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q <= in_range && (fill != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      evict_q <= hit_q ? lrukh_pkg::EVICT_W'(stamp_rd_q) : '0;
      has_q   <= hit_q;
    end
  end

  assign sts_o.is_query = (op_q == lrukh_pkg::OP_QUERY);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign evict_value_o = evict_q;
  assign has_history_o = has_q;

endmodule

// ----- rtl/lru_k_history_table.sv -----
// LRU-K access history table, top level: sequencer plus datapath.
// Depends on lrukh_pkg, lrukh_ctrl and lrukh_dp.
// An access item is captured with a metadata read, then written to its ring.
// A query item passes through metadata read, stamp memory read and result
// register in that order; a full result register stalls the last step.
// Reset (rst_ni low, asynchronous) empties every ring at once; a k_depth write does too.
module lru_k_history_table #(
  parameter int unsigned NUM_OBJECTS = lrukh_pkg::NUM_OBJECTS_DEF,
  parameter int unsigned MAX_K       = lrukh_pkg::MAX_K_DEF,
  parameter int unsigned STAMP_WIDTH = lrukh_pkg::STAMP_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lrukh_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [lrukh_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // object_index[7:0], access_count[39:8], access_time_ms[87:40]
  input  logic [lrukh_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // op[0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // evict_value[47:0]
  output logic [lrukh_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // has_history[0]
  output logic                              m_axis_tuser
);

  lrukh_pkg::cmd_t cmd;
  lrukh_pkg::sts_t sts;

  lrukh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lrukh_dp #(
    .NUM_OBJECTS (NUM_OBJECTS),
    .MAX_K       (MAX_K),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (s_axis_tuser),
    .object_index_i   (s_axis_tdata[7:0]),
    .access_count_i   (s_axis_tdata[39:8]),
    .access_time_ms_i (s_axis_tdata[87:40]),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .evict_value_o    (m_axis_tdata),
    .has_history_o    (m_axis_tuser)
  );

endmodule

// ----- rtl/lrukh_checker.sv -----
// Port-level checks of the LRU-K history table, bound to the top level.
// Depends on lrukh_pkg for port widths.
module lrukh_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [lrukh_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_no_history_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("result without history carries a non-zero value");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while the previous one is still in work");

  a_result_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a preceding read step");

endmodule

bind lru_k_history_table lrukh_checker u_chk (.*);
